// File: src/sbbc_pkg.sv
// ----------------------------------------------------------------------------
// sbbc_pkg: shared types and constants of the swept box brush clip
// Fixed-point widths, register indexes and the plane record.
// ----------------------------------------------------------------------------
package sbbc_pkg;

  localparam int FracBits = 16;
  localparam int FracW    = FracBits + 1;   // unsigned Q1.F
  localparam int SFracW   = FracBits + 2;   // signed Q1.F
  localparam int DistW    = 52;             // Q.22 distances
  localparam int CfgW     = 48;

  localparam logic [2:0] RegStartX  = 3'd0;
  localparam logic [2:0] RegStartY  = 3'd1;
  localparam logic [2:0] RegStartZ  = 3'd2;
  localparam logic [2:0] RegEndX    = 3'd3;
  localparam logic [2:0] RegEndY    = 3'd4;
  localparam logic [2:0] RegEndZ    = 3'd5;
  localparam logic [2:0] RegExtents = 3'd6;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [31:0] pdist;
  } plane_t;

  // Divider request: numerator below 2*den is not required; saturate handled.
  typedef struct packed {
    logic             start;
    logic [DistW-1:0] num;
    logic [DistW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FracW-1:0]  quo;
  } div_rsp_t;

endpackage

// File: src/sbbc_div.sv
// ----------------------------------------------------------------------------
// sbbc_div: restoring fraction divider
// One quotient bit a cycle; saturates at one when num >= den.
// ----------------------------------------------------------------------------
module sbbc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbbc_pkg::div_req_t req_i,
  output sbbc_pkg::div_rsp_t rsp_o
);
  import sbbc_pkg::*;

  localparam int CntW = $clog2(FracBits + 1);

  logic [DistW:0]   rem_q, rem_d;
  logic [DistW-1:0] den_q, den_d;
  logic [FracW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DistW:0]   shl;

  assign shl = {rem_q[DistW-1:0], 1'b0};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d = req_i.den;
      rem_d = {1'b0, req_i.num};
      quo_d = '0;
      cnt_d = '0;
      if (req_i.num >= req_i.den) begin
        quo_d  = FracW'(1) << FracBits;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (shl >= {1'b0, den_q}) begin
        rem_d = shl - {1'b0, den_q};
        quo_d = {quo_q[FracW-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[FracW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(FracBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> quo_q <= (FracW'(1) << FracBits)) else $error("quotient above one");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held two cycles");

endmodule

// File: src/swept_box_brush_clip.sv
// ----------------------------------------------------------------------------
// swept_box_brush_clip: swept box against convex solids, plane by plane
// Clips a box sweep against one bounding plane per transaction and reports
// the best fraction on the last plane of each solid.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
//  plane     in         in_valid_i/in_stall_o   normal, plane_dist, flags
//  result    out        out_valid_o/out_stall_i fraction, hit plane, flags
//
//  A plane passes the multiply, decide and fold steps, and the divide step
//  too when it needs a division; a plane of a solid already missed goes
//  straight to the fold. A 33x17 signed multiplier is shared over ten
//  products and the restoring divider yields one quotient bit a cycle.
//  Reset clears configuration and flags to zero, sets enter to minus one and exit and best to one.
//  The plane input stalls while a plane is in work or a result is waiting.
//  A waiting result holds until the result stall drops.
// ----------------------------------------------------------------------------
module swept_box_brush_clip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [sbbc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            normal_x_i,
  input  logic signed [15:0]            normal_y_i,
  input  logic signed [15:0]            normal_z_i,
  input  logic signed [31:0]            plane_dist_i,
  input  logic                          first_side_i,
  input  logic                          last_side_i,
  input  logic                          new_trace_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sbbc_pkg::FracW-1:0]    fraction_o,
  output logic signed [15:0]            hit_normal_x_o,
  output logic signed [15:0]            hit_normal_y_o,
  output logic signed [15:0]            hit_normal_z_o,
  output logic signed [31:0]            hit_plane_dist_o,
  output logic                          start_solid_o,
  output logic                          all_solid_o
);
  import sbbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DECIDE, S_DIV, S_FOLD, S_OUT
  } state_e;

  localparam logic signed [DistW-1:0] Eps = DistW'(1) <<< 19;
  localparam logic signed [SFracW-1:0] FOne = SFracW'(1) <<< FracBits;

  // configuration
  logic signed [31:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
  logic [47:0]        ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
      ex_q <= '0; ey_q <= '0; ez_q <= '0;
      ext_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStartX:  sx_q  <= cfg_data_i[31:0];
        RegStartY:  sy_q  <= cfg_data_i[31:0];
        RegStartZ:  sz_q  <= cfg_data_i[31:0];
        RegEndX:    ex_q  <= cfg_data_i[31:0];
        RegEndY:    ey_q  <= cfg_data_i[31:0];
        RegEndZ:    ez_q  <= cfg_data_i[31:0];
        RegExtents: ext_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  state_e state_q;
  logic [3:0] step_q;
  plane_t     pl_q;
  logic       last_q;

  // accumulators for pushed distance, d1 and d2 (Q.22)
  logic signed [DistW-1:0] push_q, d1_q, d2_q;
  logic                    neg_q;   // exit path: negate quotient

  // solid and trace state
  logic signed [SFracW-1:0] enter_q, exit_q;
  logic                     gets_out_q, starts_out_q, missed_q;
  plane_t                   enter_pl_q, best_pl_q;
  logic [FracW-1:0]         best_q;
  logic [1:0]               flags_q;

  // shared multiplier: 33-bit signed by 17-bit signed
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic [15:0] anx, any, anz;

  assign anx = pl_q.nx[15] ? 16'(-pl_q.nx) : pl_q.nx;
  assign any = pl_q.ny[15] ? 16'(-pl_q.ny) : pl_q.ny;
  assign anz = pl_q.nz[15] ? 16'(-pl_q.nz) : pl_q.nz;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      4'd0: begin mul_a = 33'($signed(pl_q.pdist)); mul_b = 17'sd16384; end
      4'd1: begin mul_a = {17'd0, ext_q[15:0]};  mul_b = {1'b0, anx}; end
      4'd2: begin mul_a = {17'd0, ext_q[31:16]}; mul_b = {1'b0, any}; end
      4'd3: begin mul_a = {17'd0, ext_q[47:32]}; mul_b = {1'b0, anz}; end
      4'd4: begin mul_a = 33'(sx_q); mul_b = 17'($signed(pl_q.nx)); end
      4'd5: begin mul_a = 33'(sy_q); mul_b = 17'($signed(pl_q.ny)); end
      4'd6: begin mul_a = 33'(sz_q); mul_b = 17'($signed(pl_q.nz)); end
      4'd7: begin mul_a = 33'(ex_q); mul_b = 17'($signed(pl_q.nx)); end
      4'd8: begin mul_a = 33'(ey_q); mul_b = 17'($signed(pl_q.ny)); end
      4'd9: begin mul_a = 33'(ez_q); mul_b = 17'($signed(pl_q.nz)); end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic signed [49:0] prod_q;
  logic [3:0]         pstep_q;
  logic               pvalid_q;
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // decision on d1, d2
  logic miss_c, any_out_c, enter_c;
  logic signed [DistW-1:0] enum_c, xnum_c, den_c;
  assign miss_c    = (d1_q > 0) && ((d2_q >= Eps) || (d2_q >= d1_q));
  assign any_out_c = (d1_q > 0) || (d2_q > 0);
  assign enter_c   = d1_q > d2_q;
  assign enum_c    = d1_q - Eps;
  assign xnum_c    = d1_q + Eps;
  assign den_c     = enter_c ? d1_q - d2_q : d2_q - d1_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sbbc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  logic skip_div_c;     // enter path with non-positive numerator gives zero
  assign skip_div_c = enter_c && (enum_c <= 0);

  always_comb begin
    div_req.start = 1'b0;
    div_req.den   = den_c;
    div_req.num   = enter_c ? enum_c : (xnum_c[DistW-1] ? -xnum_c : xnum_c);
    if (state_q == S_DECIDE && !missed_q && !miss_c && any_out_c && !skip_div_c)
      div_req.start = 1'b1;
  end

  // fraction update as a signed value
  function automatic logic signed [SFracW-1:0] sq(input logic [FracW-1:0] q);
    sq = $signed({1'b0, q});
  endfunction

  logic signed [SFracW-1:0] enter_new, exit_new;
  assign enter_new = skip_div_c ? '0 : sq(div_rsp.quo);
  assign exit_new  = neg_q ? -sq(div_rsp.quo) : sq(div_rsp.quo);

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      pstep_q      <= '0;
      pvalid_q     <= 1'b0;
      pl_q         <= '0;
      last_q       <= 1'b0;
      push_q       <= '0;
      d1_q         <= '0;
      d2_q         <= '0;
      neg_q        <= 1'b0;
      enter_q      <= -FOne;
      exit_q       <= FOne;
      gets_out_q   <= 1'b0;
      starts_out_q <= 1'b0;
      missed_q     <= 1'b0;
      enter_pl_q   <= '0;
      best_q       <= FracW'(1) << FracBits;
      best_pl_q    <= '0;
      flags_q      <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            pl_q   <= '{nx: normal_x_i, ny: normal_y_i, nz: normal_z_i,
                        pdist: plane_dist_i};
            last_q <= last_side_i;
            if (new_trace_i) begin
              best_q    <= FracW'(1) << FracBits;
              best_pl_q <= '0;
              flags_q   <= '0;
            end
            if (first_side_i) begin
              enter_q      <= -FOne;
              exit_q       <= FOne;
              gets_out_q   <= 1'b0;
              starts_out_q <= 1'b0;
              missed_q     <= 1'b0;
              enter_pl_q   <= '0;
            end
            step_q   <= '0;
            pvalid_q <= 1'b0;
            state_q  <= (first_side_i || !missed_q) ? S_MUL : S_FOLD;
          end
        end
        S_MUL: begin
          // issue one product a cycle, accumulate it in the cycle after
          pvalid_q <= (step_q <= 4'd9);
          pstep_q  <= step_q;
          if (step_q <= 4'd9) step_q <= step_q + 1'b1;
          if (pvalid_q) begin
            priority case (1'b1)
              pstep_q == 4'd0: push_q <= DistW'(prod_q);
              pstep_q <= 4'd3: push_q <= push_q + (DistW'(prod_q) <<< 4);
              pstep_q == 4'd4: d1_q <= DistW'(prod_q) - push_q;
              pstep_q <= 4'd6: d1_q <= d1_q + DistW'(prod_q);
              pstep_q == 4'd7: d2_q <= DistW'(prod_q) - push_q;
              default:         d2_q <= d2_q + DistW'(prod_q);
            endcase
            if (pstep_q == 4'd9) state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (missed_q) begin
            state_q <= S_FOLD;
          end else begin
            if (d2_q > 0) gets_out_q <= 1'b1;
            if (d1_q > 0) starts_out_q <= 1'b1;
            neg_q <= !xnum_c[DistW-1];
            if (miss_c) begin
              missed_q <= 1'b1;
              state_q  <= S_FOLD;
            end else if (!any_out_c) begin
              state_q <= S_FOLD;
            end else if (skip_div_c) begin
              if (enter_new > enter_q) begin
                enter_q    <= enter_new;
                enter_pl_q <= pl_q;
              end
              state_q <= S_FOLD;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (enter_c) begin
              if (enter_new > enter_q) begin
                enter_q    <= enter_new;
                enter_pl_q <= pl_q;
              end
            end else if (exit_new < exit_q) begin
              exit_q <= exit_new;
            end
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            if (!missed_q) begin
              if (!starts_out_q) begin
                flags_q[0] <= 1'b1;
                if (!gets_out_q) begin
                  flags_q[1] <= 1'b1;
                  best_q     <= '0;
                end
              end else if (enter_q < exit_q && enter_q > -FOne &&
                           enter_q < sq(best_q)) begin
                best_q    <= enter_q[SFracW-1] ? '0 : enter_q[FracW-1:0];
                best_pl_q <= enter_pl_q;
              end
            end
            out_valid_o <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign fraction_o       = best_q;
  assign hit_normal_x_o   = best_pl_q.nx;
  assign hit_normal_y_o   = best_pl_q.ny;
  assign hit_normal_z_o   = best_pl_q.nz;
  assign hit_plane_dist_o = best_pl_q.pdist;
  assign start_solid_o    = flags_q[0];
  assign all_solid_o      = flags_q[1];

  a_valid_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT) else $error("result shown outside output state");
  a_all_implies_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[1] |-> flags_q[0]) else $error("all-solid without start-solid");
  a_all_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flags_q[1]) |-> best_q == '0) else $error("all-solid fraction not zero");
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= (FracW'(1) << FracBits)) else $error("best fraction above one");

endmodule
